@@ sv/lru_key_value_cache_core_defines.svh @@
// ----------------------------------------------------------------------------
// LRU key-value cache assertion macros
// Shared concurrent assertion forms, clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef LRU_KEY_VALUE_CACHE_CORE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_CORE_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define LKVC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A next-cycle implication: when the trigger holds, the check holds at the following edge.
`define LKVC_ASSERT_NEXT(lbl, trig, chk, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (chk)) \
    else $error(msg);

`endif

@@ sv/lkvc_pkg.sv @@
// ----------------------------------------------------------------------------
// LRU key-value cache package
// Field widths, command codes and the entry type shared by the cache files.
// ----------------------------------------------------------------------------
package lkvc_pkg;

  localparam int unsigned KEY_W = 32;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned CAP_W = 5;

  // Capacity after reset.
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Command codes.
  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_SET = 1'b1;

  typedef logic signed [KEY_W-1:0] key_t;
  typedef logic signed [VAL_W-1:0] val_t;

  // One cache entry as it travels along the chain.
  typedef struct packed {
    logic valid;
    key_t key;
    val_t value;
  } lkvc_entry_t;

endpackage

@@ sv/lkvc_if.sv @@
// ----------------------------------------------------------------------------
// LRU key-value cache channels
// Valid/ready interfaces for request words and response words.
// ----------------------------------------------------------------------------
interface lkvc_in_if;
  logic                valid;
  logic                ready;
  logic                cmd;
  logic signed [31:0]  key;
  logic signed [31:0]  value;

  modport source (output valid, output cmd, output key, output value, input ready);
  modport sink   (input valid, input cmd, input key, input value, output ready);
endinterface

interface lkvc_out_if;
  logic                valid;
  logic                ready;
  logic                hit;
  logic signed [31:0]  read_value;

  modport source (output valid, output hit, output read_value, input ready);
  modport sink   (input valid, input hit, input read_value, output ready);
endinterface

@@ sv/lru_key_value_cache_core.sv @@
// ----------------------------------------------------------------------------
// LRU key-value cache core
// Fully associative key-value store with least-recently-used replacement,
// built as a chain of cells kept in recency order.
// ----------------------------------------------------------------------------
// The cache takes one request word per clock cycle: every word is looked up,
// applied and answered at the edge that accepts it, and its response word is
// held in an output register until the sink takes it. While a response waits,
// the request side stalls; a new word is accepted in the same cycle that the
// pending response leaves. That rate comes from the chain of
// cells: all cells compare the key at once and every affected cell loads its
// neighbor in that same cycle. A get returns hit and the stored value (zero on
// a miss, and zero for every set). Entries live in recency order, cell 0 being
// the most recent, so the least recent valid entry always sits at the end of
// the valid prefix and eviction simply lets it be overwritten by the shift.
// The capacity register may be written only while the cache is idle; zero acts
// as one and values above ENTRIES act as ENTRIES. No clearing pass is needed
// after reset: valid bits and the entry count clear at once.
// ----------------------------------------------------------------------------
`include "lru_key_value_cache_core_defines.svh"

module lru_key_value_cache_core #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [lkvc_pkg::CAP_W-1:0]   cfg_wdata_i,
  lkvc_in_if.sink                      in_i,
  lkvc_out_if.source                   out_o
);
  import lkvc_pkg::*;

  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
  localparam int unsigned CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  // Configuration and occupancy.
  logic [CAP_W-1:0] cap_q;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CMP_W-1:0] cap_eff;

  // Chain signals.
  lkvc_entry_t      cell_entry [ENTRIES];
  lkvc_entry_t      front_entry;
  logic [ENTRIES-1:0] match;
  logic [ENTRIES-1:0] shift;
  logic [ENTRIES-1:0] valid_vec;

  logic fire;
  logic is_set;
  logic hit;
  logic evict;
  logic insert;
  val_t hit_value;

  // Output register.
  logic out_valid_q;
  logic out_hit_q;
  val_t out_rdata_q;

  // Views used by the checks at the end of the module.
  logic valid_prefix_ok;
  key_t head_key;

  assign fire       = in_i.valid && in_i.ready;
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign is_set     = (in_i.cmd == CMD_SET);
  assign hit        = |match;

  // Matches are one-hot, so an OR of the gated values selects the hit entry.
  always_comb begin
    hit_value = '0;
    for (int unsigned i = 0; i < ENTRIES; i++) begin
      hit_value = hit_value | (match[i] ? cell_entry[i].value : '0);
    end
  end

  // Clamp the capacity to the range 1 .. ENTRIES.
  always_comb begin
    if (cap_q == '0) begin
      cap_eff = CMP_W'(1);
    end else if (CMP_W'(cap_q) > CMP_W'(ENTRIES)) begin
      cap_eff = CMP_W'(ENTRIES);
    end else begin
      cap_eff = CMP_W'(cap_q);
    end
  end

  assign evict  = CMP_W'(count_q) >= cap_eff;
  assign insert = fire && is_set && !hit;

  // The word that enters at the head of the chain: the requested key, with the
  // new value on a set or the current value when a get refreshes an entry.
  assign front_entry.valid = 1'b1;
  assign front_entry.key   = in_i.key;
  assign front_entry.value = is_set ? in_i.value : hit_value;

  // The head cell loads on any hit and on any set; a get miss leaves all alone.
  assign shift[0] = fire && (hit || is_set);

  for (genvar g = 0; g < ENTRIES; g++) begin : g_chain
    if (g > 0) begin : g_shift
      localparam logic [CNT_W-1:0] POS = CNT_W'(g);
      logic miss_shift;

      // On an insert, cells up to the end of the valid prefix move down; when
      // the cache is full the last valid cell is overwritten, which evicts it.
      assign miss_shift = is_set && (evict ? (POS < count_q) : (POS <= count_q));

      // On a hit, cells from the head down to the hit position move down.
      assign shift[g] = fire && (hit ? (|match[ENTRIES-1:g]) : miss_shift);
    end

    lkvc_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .shift_i      (shift[g]),
      .prev_i       ((g == 0) ? front_entry : cell_entry[(g == 0) ? 0 : g - 1]),
      .lookup_key_i (in_i.key),
      .entry_o      (cell_entry[g]),
      .match_o      (match[g])
    );

    assign valid_vec[g] = cell_entry[g].valid;
  end

  // The count grows only when an insert finds room.
  always_comb begin
    count_d = count_q;
    if (insert && !evict) begin
      count_d = count_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= CAP_RESET;
      count_q <= '0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_hit_q   <= hit;
      out_rdata_q <= (!is_set && hit) ? hit_value : '0;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.hit        = out_hit_q;
  assign out_o.read_value = out_rdata_q;

  // The valid cells form a prefix of the chain as long as the entry count.
  assign valid_prefix_ok = (CNT_W'($countones(valid_vec)) == count_q) &&
                           (((valid_vec + 1'b1) & valid_vec) == '0);
  assign head_key        = cell_entry[0].key;

  // A key is held by at most one valid cell.
  `LKVC_ASSERT(a_match_unique, $onehot0(match), "key present in more than one cell")
  // Valid cells form a prefix of the chain whose length is the entry count.
  `LKVC_ASSERT(a_valid_prefix, valid_prefix_ok, "valid cells do not match the entry count")
  // The count never exceeds the number of cells.
  `LKVC_ASSERT(a_count_bound, count_q <= CNT_W'(ENTRIES), "entry count above the number of cells")
  // A hit moves the looked-up key to the head of the chain.
  `LKVC_ASSERT_NEXT(a_hit_to_head, fire && hit, head_key == $past(in_i.key), "hit not at head")

endmodule

@@ sv/lkvc_cell.sv @@
// ----------------------------------------------------------------------------
// LRU key-value cache cell
// One slot of the recency chain: holds an entry, compares it against the
// lookup key and loads its upstream neighbor when told to shift.
// ----------------------------------------------------------------------------
module lkvc_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                shift_i,
  input  lkvc_pkg::lkvc_entry_t prev_i,
  input  lkvc_pkg::key_t      lookup_key_i,
  output lkvc_pkg::lkvc_entry_t entry_o,
  output logic                match_o
);
  import lkvc_pkg::*;

  logic valid_q;
  key_t key_q;
  val_t value_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (shift_i) begin
      valid_q <= prev_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      key_q   <= prev_i.key;
      value_q <= prev_i.value;
    end
  end

  assign entry_o.valid = valid_q;
  assign entry_o.key   = key_q;
  assign entry_o.value = value_q;
  assign match_o       = valid_q && (key_q == lookup_key_i);

endmodule

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// LRU key-value cache testbench
// Drives get and set words through the cache under random idling, keeps a
// shadow copy of the entry table with its recency order, and checks every
// response word against it.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lkvc_pkg::*;

  localparam int unsigned ENTRIES = 16;

  // One expected response word.
  typedef struct {
    logic hit;
    val_t read_value;
  } lookup_result_t;

  // --------------------------------------------------------------------------
  // Shadow of the cache: the same table, the same recency ranks, the same
  // capacity. Each accepted request word is applied here at once and the
  // response it must produce is queued until the cache delivers it.
  // --------------------------------------------------------------------------
  class lru_shadow;
    key_t           slot_key[ENTRIES];
    val_t           slot_value[ENTRIES];
    bit             slot_valid[ENTRIES];
    int unsigned    slot_age[ENTRIES];   // 0 is the most recent entry
    int unsigned    occupancy;
    logic [CAP_W-1:0] capacity;
    lookup_result_t awaited[$];
    int unsigned    mismatches;

    function new();
      capacity   = CAP_RESET;
      occupancy  = 0;
      mismatches = 0;
      foreach (slot_valid[i]) begin
        slot_valid[i] = 1'b0;
        slot_age[i]   = 0;
      end
    endfunction

    function void set_capacity(logic [CAP_W-1:0] cap);
      capacity = cap;
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction

    // Zero behaves as one, anything past the table size as the table size.
    function int unsigned usable_capacity();
      int unsigned c;
      c = capacity;
      if (c == 0) c = 1;
      if (c > ENTRIES) c = ENTRIES;
      return c;
    endfunction

    // Move a valid entry to the front; only the entries ahead of it age.
    function void promote(int idx);
      int unsigned r;
      r = slot_age[idx];
      foreach (slot_valid[i])
        if (slot_valid[i] && slot_age[i] < r) slot_age[i]++;
      slot_age[idx] = 0;
    endfunction

    function void evict_least_recent();
      int victim;
      victim = -1;
      foreach (slot_valid[i])
        if (slot_valid[i] && (victim < 0 || slot_age[i] > slot_age[victim])) victim = i;
      if (victim >= 0) begin
        slot_valid[victim] = 1'b0;
        if (occupancy > 0) occupancy--;
      end
    endfunction

    function void note_request(logic cmd, key_t key, val_t value);
      int found;
      int free_slot;
      lookup_result_t res;
      found = -1;
      foreach (slot_valid[i])
        if (found < 0 && slot_valid[i] && slot_key[i] == key) found = i;
      res.hit        = (found >= 0);
      res.read_value = '0;
      if (cmd == CMD_GET) begin
        if (found >= 0) begin
          res.read_value = slot_value[found];
          promote(found);
        end
      end else if (found >= 0) begin
        slot_value[found] = value;
        promote(found);
      end else begin
        // A lowered capacity still evicts only one entry per insert.
        if (occupancy >= usable_capacity()) evict_least_recent();
        free_slot = -1;
        foreach (slot_valid[i])
          if (free_slot < 0 && !slot_valid[i]) free_slot = i;
        if (free_slot >= 0) begin
          foreach (slot_valid[i])
            if (slot_valid[i]) slot_age[i]++;
          slot_valid[free_slot] = 1'b1;
          slot_key[free_slot]   = key;
          slot_value[free_slot] = value;
          slot_age[free_slot]   = 0;
          occupancy++;
        end
      end
      awaited.push_back(res);
    endfunction

    function void flag(string field, logic [31:0] exp_v, logic [31:0] act_v);
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR at %0t: %s expected %0d (0x%08h), got %0d (0x%08h)", $realtime,
                 field, $signed(exp_v), exp_v, $signed(act_v), act_v);
    endfunction

    function void check_response(logic hit, val_t read_value);
      lookup_result_t res;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR at %0t: response word with no request outstanding (hit %0b, value %0d)",
                   $realtime, hit, read_value);
        return;
      end
      res = awaited.pop_front();
      if (hit !== res.hit) flag("hit", 32'(res.hit), 32'(hit));
      if (read_value !== res.read_value) flag("read_value", res.read_value, read_value);
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CAP_W-1:0] cfg_wdata_i;

  // When set, neither side idles: this gives a stretch of back-to-back words.
  bit               no_idle;

  lkvc_in_if  req_if ();
  lkvc_out_if rsp_if ();

  lru_shadow shadow = new();

  lru_key_value_cache_core #(
    .ENTRIES(ENTRIES)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (req_if),
    .out_o      (rsp_if)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // The response sink holds off at random, about 28 times in a hundred.
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      rsp_if.ready <= no_idle || ($urandom_range(99) >= 28);
    end
  end

  // Both channels are observed at the edge itself, so every word seen here is
  // one that the handshake really moved. Responses are checked before the
  // request of the same edge is noted; the response always belongs to an
  // older request anyway.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) shadow.check_response(rsp_if.hit, rsp_if.read_value);
      if (req_if.valid && req_if.ready)
        shadow.note_request(req_if.cmd, req_if.key, req_if.value);
    end
  end

  // Present one request word and hold it until it is taken. Ready is looked
  // at on the falling edge, where it has settled, and the word counts as
  // taken at the following rising edge. Valid stays high on return so that
  // the next word can follow without a bubble.
  task automatic send_request(input logic cmd, input key_t key, input val_t value);
    bit taken;
    if (!no_idle && $urandom_range(99) < 28) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.cmd   <= cmd;
    req_if.key   <= key;
    req_if.value <= value;
    do begin
      @(negedge clk_i);
      taken = req_if.ready;
      @(posedge clk_i);
    end while (!taken);
  endtask

  // Stop sending and wait until every response word has come back.
  task automatic drain();
    req_if.valid <= 1'b0;
    do @(negedge clk_i); while (shadow.pending() != 0);
    @(posedge clk_i);
  endtask

  // Only called with the cache idle, so the shadow may take the new value
  // at once.
  task automatic program_capacity(input logic [CAP_W-1:0] cap);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cap;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    shadow.set_capacity(cap);
  endtask

  // A random phase: most keys come from a small pool so that hits, updates,
  // recency changes and evictions are frequent; the rest are arbitrary keys
  // that almost always miss.
  task automatic random_phase(input int unsigned n_words, input int unsigned pool_size);
    key_t pool[$];
    key_t key;
    pool.delete();
    repeat (pool_size) pool.push_back(key_t'($urandom));
    repeat (n_words) begin
      if ($urandom_range(99) < 85) key = pool[$urandom_range(pool_size - 1)];
      else key = key_t'($urandom);
      send_request(logic'($urandom_range(1)), key, val_t'($urandom));
    end
  endtask

  initial begin
    int unsigned phase_cap[10];
    int unsigned phase_pool[10];

    phase_cap    = '{16, 1, 4, 0, 31, 17, 9, 2, 16, 12};
    phase_pool   = '{24, 3, 7, 3, 28, 24, 14, 4, 20, 18};
    rst_ni       <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_wdata_i  <= '0;
    req_if.valid <= 1'b0;
    req_if.cmd   <= CMD_GET;
    req_if.key   <= '0;
    req_if.value <= '0;
    no_idle      <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words at the reset capacity: a lookup in the empty cache,
    // inserts of the extreme keys and values, hits, a miss and an update of
    // a present key.
    send_request(CMD_GET, 32'sd0, 32'sd7);
    send_request(CMD_SET, 32'h7FFF_FFFF, 32'h8000_0000);
    send_request(CMD_SET, 32'h8000_0000, 32'h7FFF_FFFF);
    send_request(CMD_SET, 32'sd0, -32'sd1);
    send_request(CMD_SET, -32'sd1, 32'sd0);
    send_request(CMD_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_request(CMD_GET, 32'h8000_0000, 32'sd0);
    send_request(CMD_GET, 32'sd1, 32'sd0);
    send_request(CMD_SET, 32'sd0, 32'h1234_5678);
    send_request(CMD_GET, 32'sd0, 32'sd0);
    send_request(CMD_GET, -32'sd1, 32'sd0);
    drain();

    // Capacity dropped below the four entries in use: each new key evicts
    // exactly one, so the count stays at four.
    program_capacity(CAP_W'(2));
    send_request(CMD_SET, 32'sd5, 32'sd55);
    send_request(CMD_GET, 32'h7FFF_FFFF, 32'sd0);
    send_request(CMD_SET, 32'sd6, 32'sd66);
    send_request(CMD_GET, 32'sd5, 32'sd0);
    drain();

    // A capacity of zero acts as one.
    program_capacity(CAP_W'(0));
    send_request(CMD_SET, 32'sd7, 32'sd77);
    send_request(CMD_SET, 32'sd8, 32'sd88);
    send_request(CMD_GET, 32'sd7, 32'sd0);
    send_request(CMD_GET, 32'sd8, 32'sd0);
    drain();

    // Random phases over a spread of capacities, including zero, the largest
    // register value and values above the table size. One phase runs with
    // no idling on either side.
    for (int p = 0; p < 10; p++) begin
      program_capacity(CAP_W'(phase_cap[p]));
      no_idle <= (p == 4);
      random_phase(75, phase_pool[p]);
      drain();
    end

    repeat (4) @(posedge clk_i);
    if (shadow.mismatches == 0 && shadow.pending() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of this stimulus.
  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
